[design/pid_setpoint_with_antiwindup_assert.svh]
// Assertion macros for the set-point controller.
// Used by the top level only; depends on nothing else.
`ifndef PID_SETPOINT_WITH_ANTIWINDUP_ASSERT_SVH
`define PID_SETPOINT_WITH_ANTIWINDUP_ASSERT_SVH

// Same-cycle implication, quiet while reset is asserted.
`define PIDSAW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define PIDSAW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/pidsaw_pkg.sv]
// Shared types and constants for the set-point controller.
// No dependencies; used by every module of the block.
`default_nettype none

package pidsaw_pkg;

    // Run modes.
    localparam logic [1:0] MODE_FREE   = 2'd0;
    localparam logic [1:0] MODE_FOLLOW = 2'd1;
    localparam logic [1:0] MODE_MASTER = 2'd2;

    // Register indexes on the configuration port.
    localparam int          CFG_IDX_W        = 3;
    localparam int          CFG_DATA_W       = 16;
    localparam logic [2:0]  REG_RUN_MODE     = 3'd0;
    localparam logic [2:0]  REG_TARGET_TEMP  = 3'd1;
    localparam logic [2:0]  REG_GAIN_P       = 3'd2;
    localparam logic [2:0]  REG_GAIN_I       = 3'd3;
    localparam logic [2:0]  REG_GAIN_D       = 3'd4;
    localparam logic [2:0]  REG_INT_BAND     = 3'd5;
    localparam logic [2:0]  REG_SET_FLOOR    = 3'd6;
    localparam logic [2:0]  REG_SET_CEILING  = 3'd7;

    // Reset values of the registers.
    localparam logic signed [15:0] RST_TARGET_TEMP = 16'sd10240;
    localparam logic [14:0]        RST_INT_BAND    = 15'd256;
    localparam logic signed [15:0] RST_SET_FLOOR   = 16'sd2048;
    localparam logic signed [15:0] RST_SET_CEILING = 16'sd15360;

    // Defaults for the top-level parameters.
    localparam int UPDATE_PERIOD_DEF     = 60;
    localparam int SATURATION_MARGIN_DEF = 1024;

    typedef struct packed {
        logic [1:0]        run_mode;
        logic signed [15:0] target_temp;
        logic signed [15:0] gain_p;
        logic signed [15:0] gain_i;
        logic signed [15:0] gain_d;
        logic [14:0]        integral_band;
        logic signed [15:0] setting_floor;
        logic signed [15:0] setting_ceiling;
    } cfg_t;

endpackage

`default_nettype wire

[design/pid_setpoint_with_antiwindup.sv]
// Set-point controller with integrator anti-windup, top level; uses pidsaw_pkg,
// pidsaw_cfg, pidsaw_integ, pidsaw_terms and the assertion macro header.
// A beat passes through the input register, stages B and C and the output register.
// Throughput: one beat per cycle; the four-register pipeline stalls only when
// the output register is full and not being drained.
// Reset (rst_n, asynchronous, active low) empties the pipeline, clears the
// integral and the tick, and loads the register defaults.
`default_nettype none
`include "pid_setpoint_with_antiwindup_assert.svh"

module pid_setpoint_with_antiwindup #(
    parameter int UPDATE_PERIOD     = pidsaw_pkg::UPDATE_PERIOD_DEF,
    parameter int SATURATION_MARGIN = pidsaw_pkg::SATURATION_MARGIN_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [pidsaw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pidsaw_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic signed [15:0]                 vessel_temp,
    input  wire logic signed [15:0]                 vessel_slope,
    input  wire logic signed [15:0]                 chamber_temp,
    input  wire logic signed [15:0]                 chamber_target,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [15:0]                      suggested_setting,
    output logic                                    free_riding
);

    // Pipeline overview:
    //   stage A  input register, holds the raw beat;
    //   stage B  error, free-ride flag and the integral seen by this beat
    //            (the integrator state moves as a beat passes from A to B);
    //   stage C  the three gain products, already scaled back to 7.9;
    //   output   sum of target and terms, clamped to the setting limits.
    // Each stage advances when the one after it is empty or advancing, so
    // the ready chain runs back from out_ready to in_ready.

    pidsaw_pkg::cfg_t cfg;

    pidsaw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Valid bits of the stages.
    logic a_valid_reg, a_valid_next;
    logic b_valid_reg, b_valid_next;
    logic c_valid_reg, c_valid_next;
    logic o_valid_reg, o_valid_next;

    logic en_a, en_b, en_c, en_o;

    always_comb
    begin
        en_o = !o_valid_reg || out_ready;
        en_c = !c_valid_reg || en_o;
        en_b = !b_valid_reg || en_c;
        en_a = !a_valid_reg || en_b;

        a_valid_next = en_a ? in_valid    : a_valid_reg;
        b_valid_next = en_b ? a_valid_reg : b_valid_reg;
        c_valid_next = en_c ? b_valid_reg : c_valid_reg;
        o_valid_next = en_o ? c_valid_reg : o_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    assign in_ready  = en_a;
    assign out_valid = o_valid_reg;

    // Stage A: the input register.
    logic signed [15:0] vt_a_reg;
    logic signed [15:0] slope_a_reg;
    logic signed [15:0] ch_temp_a_reg;
    logic signed [15:0] ch_set_a_reg;

    always_ff @(posedge clk)
    begin
        if (in_valid && en_a)
        begin
            vt_a_reg      <= vessel_temp;
            slope_a_reg   <= vessel_slope;
            ch_temp_a_reg <= chamber_temp;
            ch_set_a_reg  <= chamber_target;
        end
    end

    // Stage A to B: error, mode decode and the integrator step. Modes other
    // than follower and master, the unused code included, mean free ride.
    logic signed [16:0] err_a;
    logic               free_a;
    logic               master_step;
    logic signed [31:0] integral_a;

    always_comb
    begin
        err_a       = 17'(cfg.target_temp) - 17'(vt_a_reg);
        free_a      = (cfg.run_mode != pidsaw_pkg::MODE_FOLLOW)
                   && (cfg.run_mode != pidsaw_pkg::MODE_MASTER);
        master_step = a_valid_reg && en_b && (cfg.run_mode == pidsaw_pkg::MODE_MASTER);
    end

    pidsaw_integ #(
        .UPDATE_PERIOD     (UPDATE_PERIOD),
        .SATURATION_MARGIN (SATURATION_MARGIN)
    ) u_integ (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (master_step),
        .err            (err_a),
        .chamber_temp   (ch_temp_a_reg),
        .chamber_target (ch_set_a_reg),
        .cfg            (cfg),
        .integral_now   (integral_a)
    );

    logic signed [16:0] err_b_reg;
    logic signed [15:0] slope_b_reg;
    logic signed [31:0] integral_b_reg;
    logic               free_b_reg;

    always_ff @(posedge clk)
    begin
        if (a_valid_reg && en_b)
        begin
            err_b_reg      <= err_a;
            slope_b_reg    <= slope_a_reg;
            integral_b_reg <= integral_a;
            free_b_reg     <= free_a;
        end
    end

    // Stage B to C: the three products.
    logic signed [23:0] p_c;
    logic signed [38:0] i_c;
    logic signed [22:0] d_c;
    logic               free_c;

    pidsaw_terms u_terms (
        .clk      (clk),
        .en       (b_valid_reg && en_c),
        .err      (err_b_reg),
        .slope    (slope_b_reg),
        .integral (integral_b_reg),
        .free     (free_b_reg),
        .cfg      (cfg),
        .p_term   (p_c),
        .i_term   (i_c),
        .d_term   (d_c),
        .free_out (free_c)
    );

    // Stage C to output: full-width sum and clamp. The floor test comes
    // first, so with the floor above the ceiling a low sum still gives the
    // floor.
    logic signed [40:0] sum_c;
    logic signed [15:0] setting_c;
    logic signed [15:0] setting_reg;
    logic               free_reg;

    always_comb
    begin
        sum_c = 41'(cfg.target_temp) + 41'(p_c) + 41'(i_c) + 41'(d_c);
        if (free_c)
            setting_c = '0;
        else if (sum_c < 41'(cfg.setting_floor))
            setting_c = cfg.setting_floor;
        else if (sum_c > 41'(cfg.setting_ceiling))
            setting_c = cfg.setting_ceiling;
        else
            setting_c = sum_c[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (c_valid_reg && en_o)
        begin
            setting_reg <= setting_c;
            free_reg    <= free_c;
        end
    end

    assign suggested_setting = setting_reg;
    assign free_riding       = free_reg;

    // Checks on the pipeline control and on the free-ride result.
    `PIDSAW_ASSERT_NOW(a_stall_full, clk, rst_n, !in_ready,
        a_valid_reg && b_valid_reg && c_valid_reg && o_valid_reg && !out_ready,
        "input stalled while the pipeline has room")
    `PIDSAW_ASSERT_NEXT(a_c_held, clk, rst_n, c_valid_reg && o_valid_reg && !out_ready,
        c_valid_reg, "stage C beat lost during an output stall")
    `PIDSAW_ASSERT_NOW(a_free_zero, clk, rst_n, o_valid_reg && free_reg,
        setting_reg == '0, "free-ride beat carries a non-zero setting")

endmodule

`default_nettype wire

[design/pidsaw_cfg.sv]
// Configuration register file of the set-point controller.
// Depends on pidsaw_pkg for the register layout and reset values.
`default_nettype none

module pidsaw_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [pidsaw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pidsaw_pkg::CFG_DATA_W-1:0]   cfg_data,
    output pidsaw_pkg::cfg_t                         cfg
);

    pidsaw_pkg::cfg_t cfg_reg;
    pidsaw_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                pidsaw_pkg::REG_RUN_MODE:    cfg_next.run_mode        = cfg_data[1:0];
                pidsaw_pkg::REG_TARGET_TEMP: cfg_next.target_temp     = cfg_data;
                pidsaw_pkg::REG_GAIN_P:      cfg_next.gain_p          = cfg_data;
                pidsaw_pkg::REG_GAIN_I:      cfg_next.gain_i          = cfg_data;
                pidsaw_pkg::REG_GAIN_D:      cfg_next.gain_d          = cfg_data;
                pidsaw_pkg::REG_INT_BAND:    cfg_next.integral_band   = cfg_data[14:0];
                pidsaw_pkg::REG_SET_FLOOR:   cfg_next.setting_floor   = cfg_data;
                pidsaw_pkg::REG_SET_CEILING: cfg_next.setting_ceiling = cfg_data;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.run_mode        <= pidsaw_pkg::MODE_FREE;
            cfg_reg.target_temp     <= pidsaw_pkg::RST_TARGET_TEMP;
            cfg_reg.gain_p          <= '0;
            cfg_reg.gain_i          <= '0;
            cfg_reg.gain_d          <= '0;
            cfg_reg.integral_band   <= pidsaw_pkg::RST_INT_BAND;
            cfg_reg.setting_floor   <= pidsaw_pkg::RST_SET_FLOOR;
            cfg_reg.setting_ceiling <= pidsaw_pkg::RST_SET_CEILING;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[design/pidsaw_integ.sv]
// Error integrator with anti-windup and the update tick.
// Depends on pidsaw_pkg for the configuration struct.
`default_nettype none

module pidsaw_integ #(
    parameter int UPDATE_PERIOD     = pidsaw_pkg::UPDATE_PERIOD_DEF,
    parameter int SATURATION_MARGIN = pidsaw_pkg::SATURATION_MARGIN_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic signed [16:0] err,
    input  wire logic signed [15:0] chamber_temp,
    input  wire logic signed [15:0] chamber_target,
    input  wire pidsaw_pkg::cfg_t   cfg,
    output logic signed [31:0]      integral_now
);

    localparam int                     TICK_W    = $clog2(UPDATE_PERIOD + 1);
    localparam logic [TICK_W-1:0]      TICK_LAST = TICK_W'(UPDATE_PERIOD);
    localparam logic signed [17:0]     MARGIN    = 18'(SATURATION_MARGIN);
    localparam logic signed [33:0]     INT_MAX   = 34'sd2147483647;
    localparam logic signed [33:0]     INT_MIN   = -34'sd2147483648;

    logic [TICK_W-1:0]  tick_reg;
    logic [TICK_W-1:0]  tick_next;
    logic signed [31:0] integral_reg;
    logic signed [31:0] integral_next;

    logic signed [17:0] err_w;
    logic signed [17:0] err_abs;
    logic signed [17:0] set_w;
    logic signed [17:0] temp_w;
    logic signed [33:0] int_w;
    logic signed [33:0] sum;
    logic signed [31:0] sum_sat;
    logic               in_band;
    logic               same_sign;
    logic               hold;
    logic               update;

    always_comb
    begin
        err_w     = 18'(err);
        err_abs   = err[16] ? -err_w : err_w;
        in_band   = err_abs[16:0] < {2'b00, cfg.integral_band};
        same_sign = (err[16] == integral_reg[31]);
        set_w     = 18'(chamber_target);
        temp_w    = 18'(chamber_temp);

        // Hold the integral while the chamber is pinned at a limit, or lags
        // its setting by more than the margin in the direction of the error.
        hold = (chamber_temp == cfg.setting_ceiling)
            || (chamber_temp == cfg.setting_floor)
            || (err[16] && (set_w + MARGIN < temp_w))
            || (!err[16] && (err != '0) && (set_w - MARGIN > temp_w));

        int_w = 34'(integral_reg);
        if (!in_band)
            sum = int_w - 34'(integral_reg >>> 3);
        else if (!same_sign)
            sum = int_w + (34'(err) <<< 2);
        else if (!hold)
            sum = int_w + 34'(err);
        else
            sum = int_w;

        if (sum > INT_MAX)
            sum_sat = INT_MAX[31:0];
        else if (sum < INT_MIN)
            sum_sat = INT_MIN[31:0];
        else
            sum_sat = sum[31:0];

        update        = step && (tick_reg == TICK_LAST);
        integral_next = update ? sum_sat : integral_reg;

        tick_next = tick_reg;
        if (step)
            tick_next = (tick_reg == TICK_LAST) ? '0 : tick_reg + TICK_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= '0;
            integral_reg <= '0;
        end
        else
        begin
            tick_reg     <= tick_next;
            integral_reg <= integral_next;
        end
    end

    // The item that steps the integrator sees the freshly updated value.
    assign integral_now = integral_next;

endmodule

`default_nettype wire

[design/pidsaw_terms.sv]
// Product stage: proportional, integral and derivative terms.
// Depends on pidsaw_pkg for the configuration struct.
`default_nettype none

module pidsaw_terms (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [16:0] err,
    input  wire logic signed [15:0] slope,
    input  wire logic signed [31:0] integral,
    input  wire logic               free,
    input  wire pidsaw_pkg::cfg_t   cfg,
    output logic signed [23:0]      p_term,
    output logic signed [38:0]      i_term,
    output logic signed [22:0]      d_term,
    output logic                    free_out
);

    logic signed [32:0] prod_p;
    logic signed [47:0] prod_i;
    logic signed [31:0] prod_d;

    logic signed [23:0] p_reg;
    logic signed [38:0] i_reg;
    logic signed [22:0] d_reg;
    logic               free_reg;

    // Dropping the low nine bits is the arithmetic shift of the 7.9 format.
    always_comb
    begin
        prod_p = 33'(err) * 33'(cfg.gain_p);
        prod_i = 48'(integral) * 48'(cfg.gain_i);
        prod_d = 32'(slope) * 32'(cfg.gain_d);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg    <= prod_p[32:9];
            i_reg    <= prod_i[47:9];
            d_reg    <= prod_d[31:9];
            free_reg <= free;
        end
    end

    assign p_term   = p_reg;
    assign i_term   = i_reg;
    assign d_term   = d_reg;
    assign free_out = free_reg;

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking bench for the set-point controller with integrator anti-windup.
// Holds its own model of the controller; depends on pidsaw_pkg and the top level
// pid_setpoint_with_antiwindup.
module tb_top;

    // The package names three run modes; the fourth code is unused and must act
    // as free ride.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // Stimulus plan: ~20 directed beats, then 15 register settings of 95 beats.
    localparam int SETUPS          = 15;
    localparam int BEATS_PER_SETUP = 95;
    // The receiver refuses beats for this long once, so that the pipe fills up.
    localparam int RX_HOLD_CYCLES  = 48;
    // The longest quiet stretch of a correct run is the receiver hold-off above,
    // or eight register writes plus the drain of the pipe; a run of random stalls
    // at 60 percent is short. The quiet limit below is many times that.
    localparam int QUIET_LIMIT     = 2000;

    typedef struct packed {
        logic signed [15:0] vessel_temp;
        logic signed [15:0] vessel_slope;
        logic signed [15:0] chamber_temp;
        logic signed [15:0] chamber_target;
    } reading_t;

    typedef struct packed {
        logic signed [15:0] setting;
        logic               free_ride;
    } outcome_t;

    // One line of the directed table: run mode and a gain shared by P, I and D,
    // the beat itself, and, where it is obvious, the result typed in.
    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] gain;
        reading_t           reading;
        logic               typed;
        outcome_t           want;
    } dir_row_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_we = 1'b0;
    logic [pidsaw_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [pidsaw_pkg::CFG_DATA_W-1:0]   cfg_data = '0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic signed [15:0]                  vessel_temp = '0;
    logic signed [15:0]                  vessel_slope = '0;
    logic signed [15:0]                  chamber_temp = '0;
    logic signed [15:0]                  chamber_target = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic signed [15:0]                  suggested_setting;
    logic                                free_riding;

    // Shadow of the registers and of the controller's own state.
    pidsaw_pkg::cfg_t cur_cfg;
    longint           integral_acc = 0;
    int unsigned      update_tick = 0;

    outcome_t    expected_settings[$];
    dir_row_t    directed_rows[$];

    int send_idle_pct = 17;
    int recv_idle_pct = 60;
    logic rx_hold_req = 1'b0;
    int rx_hold_count = 0;
    int quiet_cycles = 0;

    int mismatch_count = 0;
    int beats_in = 0;
    int results_checked = 0;
    int setups_applied = 0;
    int leak_steps = 0;
    int reversal_steps = 0;
    int add_steps = 0;
    int held_steps = 0;

    pid_setpoint_with_antiwindup i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .vessel_temp       (vessel_temp),
        .vessel_slope      (vessel_slope),
        .chamber_temp      (chamber_temp),
        .chamber_target    (chamber_target),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .suggested_setting (suggested_setting),
        .free_riding       (free_riding)
    );

    always #1 clk = ~clk;

    // Prints one line per mismatch and counts them all.
    task automatic report_mismatch(input string what);
        $display("MISMATCH after %0d results: %s", results_checked, what);
        mismatch_count++;
    endtask

    function automatic logic signed [15:0] fit16(input int v);
        if (v > 32767)
            v = 32767;
        else if (v < -32768)
            v = -32768;
        return 16'(v);
    endfunction

    // Model of the controller for one accepted beat. It moves the tick and the
    // integral exactly as the block should and returns the result that is due.
    function automatic outcome_t advance_controller(input reading_t r);
        outcome_t o;
        longint err, mag, nxt, p, i, d, sum;
        longint vt, slope, ct, cs, target, band, floor_v, ceil_v;
        bit hold;
        o = '0;
        if (cur_cfg.run_mode != pidsaw_pkg::MODE_FOLLOW
            && cur_cfg.run_mode != pidsaw_pkg::MODE_MASTER)
        begin
            // Free ride, and the unused mode with it: no suggestion, state held.
            o.free_ride = 1'b1;
            return o;
        end
        vt = $signed(r.vessel_temp);
        slope = $signed(r.vessel_slope);
        ct = $signed(r.chamber_temp);
        cs = $signed(r.chamber_target);
        target = $signed(cur_cfg.target_temp);
        band = cur_cfg.integral_band;
        floor_v = $signed(cur_cfg.setting_floor);
        ceil_v = $signed(cur_cfg.setting_ceiling);
        err = target - vt;

        // Only the master touches the integral, and then only on every
        // (UPDATE_PERIOD + 1)-th master beat.
        if (cur_cfg.run_mode == pidsaw_pkg::MODE_MASTER)
        begin
            if (update_tick == pidsaw_pkg::UPDATE_PERIOD_DEF)
            begin
                update_tick = 0;
                nxt = integral_acc;
                mag = (err < 0) ? -err : err;
                if (mag >= band)
                begin
                    // Outside the band the integral leaks by an eighth.
                    nxt = integral_acc - (integral_acc >>> 3);
                    leak_steps++;
                end
                else if ((err >= 0) != (integral_acc >= 0))
                begin
                    // Error pulling against the integral: four times the error.
                    nxt = integral_acc + 4 * err;
                    reversal_steps++;
                end
                else
                begin
                    hold = (ct == ceil_v) || (ct == floor_v)
                        || (err < 0 && cs + pidsaw_pkg::SATURATION_MARGIN_DEF < ct)
                        || (err > 0 && cs - pidsaw_pkg::SATURATION_MARGIN_DEF > ct);
                    if (hold)
                    begin
                        held_steps++;
                    end
                    else
                    begin
                        nxt = integral_acc + err;
                        add_steps++;
                    end
                end
                if (nxt > 64'sd2147483647)
                    nxt = 64'sd2147483647;
                else if (nxt < -64'sd2147483648)
                    nxt = -64'sd2147483648;
                integral_acc = nxt;
            end
            else
            begin
                update_tick++;
            end
        end

        p = ($signed(cur_cfg.gain_p) * err) >>> 9;
        i = ($signed(cur_cfg.gain_i) * integral_acc) >>> 9;
        d = ($signed(cur_cfg.gain_d) * slope) >>> 9;
        sum = target + p + i + d;
        // With the limits crossed over, a sum below the floor still gets the floor.
        if (sum < floor_v)
            sum = floor_v;
        else if (sum > ceil_v)
            sum = ceil_v;
        o.setting = sum[15:0];
        return o;
    endfunction

    function automatic dir_row_t make_row(input logic [1:0] mode, input int gain,
                                          input int vt, input int slope,
                                          input int ct, input int cs,
                                          input bit typed, input int want_set,
                                          input bit want_free);
        dir_row_t row;
        row.mode = mode;
        row.gain = 16'(gain);
        row.reading.vessel_temp = 16'(vt);
        row.reading.vessel_slope = 16'(slope);
        row.reading.chamber_temp = 16'(ct);
        row.reading.chamber_target = 16'(cs);
        row.typed = typed;
        row.want.setting = 16'(want_set);
        row.want.free_ride = want_free;
        return row;
    endfunction

    function automatic logic signed [15:0] random_gain();
        case ($urandom_range(0, 7))
            0: return 16'sd32767;
            1: return -16'sd32768;
            2: return 16'sd0;
            3, 4: return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 2048)) - 1024);
        endcase
    endfunction

    // Register setting for one stretch of random beats. The first two are the
    // extremes: crossed limits with full positive gains, then the widest limits
    // with full negative gains and an empty band.
    function automatic pidsaw_pkg::cfg_t random_setup(input int setup_no);
        pidsaw_pkg::cfg_t c;
        c.run_mode = pidsaw_pkg::MODE_MASTER;
        if (setup_no == 0)
        begin
            c.target_temp = 16'sd32767;
            c.gain_p = 16'sd32767;
            c.gain_i = 16'sd32767;
            c.gain_d = 16'sd32767;
            c.integral_band = 15'h7fff;
            c.setting_floor = 16'sd32767;
            c.setting_ceiling = -16'sd32768;
        end
        else if (setup_no == 1)
        begin
            c.target_temp = -16'sd32768;
            c.gain_p = -16'sd32768;
            c.gain_i = -16'sd32768;
            c.gain_d = -16'sd32768;
            c.integral_band = 15'd0;
            c.setting_floor = -16'sd32768;
            c.setting_ceiling = 16'sd32767;
        end
        else
        begin
            case ($urandom_range(0, 9))
                5, 6: c.run_mode = pidsaw_pkg::MODE_FOLLOW;
                7: c.run_mode = pidsaw_pkg::MODE_FREE;
                8: c.run_mode = MODE_SPARE;
                default: c.run_mode = pidsaw_pkg::MODE_MASTER;
            endcase
            if ($urandom_range(0, 7) == 0)
                c.target_temp = 16'($urandom);
            else
                c.target_temp = 16'($urandom_range(5000, 15000));
            c.gain_p = random_gain();
            c.gain_i = random_gain();
            c.gain_d = random_gain();
            case ($urandom_range(0, 5))
                0: c.integral_band = 15'd0;
                1: c.integral_band = 15'h7fff;
                default: c.integral_band = 15'($urandom_range(1, 2048));
            endcase
            if ($urandom_range(0, 4) == 0)
            begin
                c.setting_floor = 16'($urandom_range(8000, 16000));
                c.setting_ceiling = 16'($urandom_range(0, 7999));
            end
            else
            begin
                c.setting_floor = 16'($urandom_range(0, 6000));
                c.setting_ceiling = 16'($urandom_range(9000, 20000));
            end
        end
        return c;
    endfunction

    // Random beat. Most vessel readings sit near the target so that the error
    // lands inside the band, and the chamber often sits on a limit or past the
    // saturation margin, which is where the anti-windup decisions are made.
    function automatic reading_t random_reading();
        reading_t r;
        int v, cs, ct;
        if ($urandom_range(0, 9) < 7)
        begin
            v = $signed(cur_cfg.target_temp);
            if ($urandom_range(0, 7) != 0)
                v += int'($urandom_range(0, 1200)) - 600;
            r.vessel_temp = fit16(v);
        end
        else
        begin
            r.vessel_temp = 16'($urandom);
        end
        if ($urandom_range(0, 1) == 0)
            r.vessel_slope = 16'($urandom);
        else
            r.vessel_slope = 16'(int'($urandom_range(0, 1024)) - 512);
        if ($urandom_range(0, 3) == 0)
            cs = $signed(16'($urandom));
        else
            cs = int'($urandom_range(0, 16384));
        case ($urandom_range(0, 9))
            0: ct = $signed(cur_cfg.setting_floor);
            1: ct = $signed(cur_cfg.setting_ceiling);
            2: ct = cs + pidsaw_pkg::SATURATION_MARGIN_DEF + int'($urandom_range(1, 600));
            3: ct = cs - pidsaw_pkg::SATURATION_MARGIN_DEF - int'($urandom_range(1, 600));
            4: ct = cs + pidsaw_pkg::SATURATION_MARGIN_DEF;
            5: ct = $signed(16'($urandom));
            default: ct = cs + int'($urandom_range(0, 1600)) - 800;
        endcase
        r.chamber_target = 16'(cs);
        r.chamber_temp = fit16(ct);
        return r;
    endfunction

    task automatic write_reg(input logic [pidsaw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pidsaw_pkg::CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // Writes every register; only called while nothing is in flight.
    task automatic apply_setup(input pidsaw_pkg::cfg_t c);
        write_reg(pidsaw_pkg::REG_RUN_MODE, {14'd0, c.run_mode});
        write_reg(pidsaw_pkg::REG_TARGET_TEMP, c.target_temp);
        write_reg(pidsaw_pkg::REG_GAIN_P, c.gain_p);
        write_reg(pidsaw_pkg::REG_GAIN_I, c.gain_i);
        write_reg(pidsaw_pkg::REG_GAIN_D, c.gain_d);
        write_reg(pidsaw_pkg::REG_INT_BAND, {1'b0, c.integral_band});
        write_reg(pidsaw_pkg::REG_SET_FLOOR, c.setting_floor);
        write_reg(pidsaw_pkg::REG_SET_CEILING, c.setting_ceiling);
        cfg_we <= 1'b0;
        cur_cfg = c;
        setups_applied++;
    endtask

    // Stops offering beats and waits until every result that is due has come.
    task automatic settle_block();
        in_valid <= 1'b0;
        while (expected_settings.size() != 0)
            @(posedge clk);
    endtask

    // Offers one beat, possibly after a random gap, and waits for it to be taken.
    // Valid stays high on return so that back-to-back beats need no second write
    // of it within one time step.
    task automatic push_reading(input reading_t r, input bit typed,
                                input outcome_t typed_want);
        outcome_t due;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        vessel_temp <= r.vessel_temp;
        vessel_slope <= r.vessel_slope;
        chamber_temp <= r.chamber_temp;
        chamber_target <= r.chamber_target;
        // Signals read just after the edge still hold their pre-edge values,
        // so this sees the handshake exactly as the block did.
        do
            @(posedge clk);
        while (!in_ready);
        due = advance_controller(r);
        expected_settings.push_back(typed ? typed_want : due);
        beats_in++;
    endtask

    // Receiver: random stalls at the current rate, and once a long hold-off that
    // it counts by itself while the sender keeps offering.
    always @(posedge clk)
    begin
        if (rx_hold_req && rx_hold_count < RX_HOLD_CYCLES)
        begin
            out_ready <= 1'b0;
            rx_hold_count <= rx_hold_count + 1;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Result checker: every beat out is matched against the oldest result due.
    always @(posedge clk)
    begin : check_result
        outcome_t due;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_settings.size() == 0)
            begin
                report_mismatch($sformatf("result %0d / free %0b with nothing due",
                                          suggested_setting, free_riding));
            end
            else
            begin
                due = expected_settings.pop_front();
                if (suggested_setting !== due.setting)
                    report_mismatch($sformatf("suggested_setting %0d, expected %0d",
                                              suggested_setting, due.setting));
                if (free_riding !== due.free_ride)
                    report_mismatch($sformatf("free_riding %0b, expected %0b",
                                              free_riding, due.free_ride));
                results_checked++;
            end
        end
    end

    // Watchdog: ends the run if nothing moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("Timeout: no beat on either channel for %0d cycles", QUIET_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        dir_row_t row;
        pidsaw_pkg::cfg_t next_cfg;

        cur_cfg.run_mode = pidsaw_pkg::MODE_FREE;
        cur_cfg.target_temp = pidsaw_pkg::RST_TARGET_TEMP;
        cur_cfg.gain_p = '0;
        cur_cfg.gain_i = '0;
        cur_cfg.gain_d = '0;
        cur_cfg.integral_band = pidsaw_pkg::RST_INT_BAND;
        cur_cfg.setting_floor = pidsaw_pkg::RST_SET_FLOOR;
        cur_cfg.setting_ceiling = pidsaw_pkg::RST_SET_CEILING;

        // Free ride straight after reset: no suggestion whatever comes in.
        directed_rows.push_back(make_row(pidsaw_pkg::MODE_FREE, 0, 0, 0, 0, 0,
                                         1, 0, 1));
        directed_rows.push_back(make_row(pidsaw_pkg::MODE_FREE, 0,
                                         32767, 32767, 32767, 32767, 1, 0, 1));
        directed_rows.push_back(make_row(pidsaw_pkg::MODE_FREE, 0,
                                         -32768, -32768, -32768, -32768, 1, 0, 1));
        // The unused mode code behaves as free ride.
        directed_rows.push_back(make_row(MODE_SPARE, 0, 100, -5, 3000, -3000, 1, 0, 1));
        // With every gain at zero the suggestion is the reset target, 20 degrees.
        directed_rows.push_back(make_row(pidsaw_pkg::MODE_FOLLOW, 0, 0, 0, 0, 0,
                                         1, 10240, 0));
        directed_rows.push_back(make_row(pidsaw_pkg::MODE_FOLLOW, 0,
                                         32767, -32768, 32767, -32768, 1, 10240, 0));
        directed_rows.push_back(make_row(pidsaw_pkg::MODE_FOLLOW, 0,
                                         -32768, 32767, -32768, 32767, 1, 10240, 0));
        directed_rows.push_back(make_row(pidsaw_pkg::MODE_MASTER, 0,
                                         10240, 0, 2048, 15360, 1, 10240, 0));
        directed_rows.push_back(make_row(pidsaw_pkg::MODE_MASTER, 0,
                                         -1, 1, 15360, 2048, 1, 10240, 0));
        // Full-scale gains and readings drive the sum hard into the ceiling or floor.
        directed_rows.push_back(make_row(pidsaw_pkg::MODE_FOLLOW, 32767,
                                         -32768, 32767, 0, 0, 1, 15360, 0));
        directed_rows.push_back(make_row(pidsaw_pkg::MODE_FOLLOW, 32767,
                                         32767, -32768, 0, 0, 1, 2048, 0));
        directed_rows.push_back(make_row(pidsaw_pkg::MODE_FOLLOW, -32768,
                                         -32768, 32767, 0, 0, 1, 2048, 0));
        directed_rows.push_back(make_row(pidsaw_pkg::MODE_FOLLOW, -32768,
                                         32767, -32768, 0, 0, 1, 15360, 0));
        // Unity gains: ordinary sums checked against the model, then two free rides.
        directed_rows.push_back(make_row(pidsaw_pkg::MODE_FOLLOW, 512,
                                         10240, 0, 4000, 4200, 0, 0, 0));
        directed_rows.push_back(make_row(pidsaw_pkg::MODE_FOLLOW, 512,
                                         9728, 256, 4000, 4200, 0, 0, 0));
        directed_rows.push_back(make_row(pidsaw_pkg::MODE_FOLLOW, 512,
                                         10999, -700, 9000, 8000, 0, 0, 0));
        directed_rows.push_back(make_row(pidsaw_pkg::MODE_MASTER, 512,
                                         21845, -21846, 21845, -21846, 0, 0, 0));
        directed_rows.push_back(make_row(pidsaw_pkg::MODE_MASTER, 512,
                                         -21846, 21845, -21846, 21845, 0, 0, 0));
        directed_rows.push_back(make_row(MODE_SPARE, 512, 5000, 5000, 5000, 5000,
                                         1, 0, 1));
        directed_rows.push_back(make_row(pidsaw_pkg::MODE_FREE, 512,
                                         12000, -12000, 7, -7, 1, 0, 1));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: the mode and the shared gain change only between rows
        // once the block has drained.
        foreach (directed_rows[k])
        begin
            row = directed_rows[k];
            if (row.mode != cur_cfg.run_mode || row.gain != cur_cfg.gain_p)
            begin
                settle_block();
                next_cfg = cur_cfg;
                next_cfg.run_mode = row.mode;
                next_cfg.gain_p = row.gain;
                next_cfg.gain_i = row.gain;
                next_cfg.gain_d = row.gain;
                apply_setup(next_cfg);
            end
            push_reading(row.reading, row.typed, row.want);
        end

        // Random part. The first third stalls mostly at the receiver, the second
        // mostly at the sender, the last not at all; that last third opens with
        // the long receiver hold-off. Each setting waits for the pipe to empty.
        for (int s = 0; s < SETUPS; s++)
        begin
            settle_block();
            if (s == SETUPS / 3)
            begin
                send_idle_pct = 60;
                recv_idle_pct <= 17;
            end
            else if (s == 2 * SETUPS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            apply_setup(random_setup(s));
            if (s == 2 * SETUPS / 3)
                rx_hold_req <= 1'b1;
            repeat (BEATS_PER_SETUP)
                push_reading(random_reading(), 1'b0, '0);
        end

        settle_block();
        repeat (8) @(posedge clk);
        $display("Covered %0d beats under %0d register settings; %0d results checked.",
                 beats_in, setups_applied, results_checked);
        $display("Integral updates: %0d leaks, %0d reversals, %0d additions, %0d held.",
                 leak_steps, reversal_steps, add_steps, held_steps);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/pidsaw_pkg.sv
design/pidsaw_cfg.sv
design/pidsaw_integ.sv
design/pidsaw_terms.sv
design/pid_setpoint_with_antiwindup.sv
bench/tb_top.sv
